>>> hdl/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants for the modular arithmetic unit
// Operation codes, sequencer states, widths and the request/status structs
// exchanged between the sequencer and the shared modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mau_pkg;

  // operand field width; the sign bit is the top bit
  localparam int OPERAND_BITS = 32;
  // residue and modulus width
  localparam int RES_BITS     = 31;
  // multiplier operand width (serial bits per multiply)
  localparam int MUL_X_BITS   = 32;
  localparam int MUL_CNT_BITS = $clog2(MUL_X_BITS);
  localparam logic [RES_BITS-1:0] MODULUS_RESET = RES_BITS'(1000000007);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_INV = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_A_W,
    S_RED_B,
    S_RED_B_W,
    S_DISPATCH,
    S_POW_CHK,
    S_POW_MUL,
    S_POW_MUL_W,
    S_POW_SQR,
    S_POW_SQR_W,
    S_MUL,
    S_MUL_W,
    S_OUT
  } state_t;

  // request to the shared multiplier: start with x * y mod modulus
  typedef struct packed {
    logic                  start;
    logic [MUL_X_BITS-1:0] x;
    logic [RES_BITS-1:0]   y;
  } mul_req_t;

  // multiplier status
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [RES_BITS-1:0] prod;
  } mul_sts_t;

endpackage

`default_nettype wire

>>> hdl/mau_mulmod.sv
// ----------------------------------------------------------------------------
// mau_mulmod: bit-serial modular multiplier
// Interleaved shift-add multiply with reduction: one bit of x per cycle,
// MSB first. Needs y below the modulus; x may be any 32-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module mau_mulmod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mau_pkg::mul_req_t            req,
  input  logic [mau_pkg::RES_BITS-1:0] modulus,
  output mau_pkg::mul_sts_t            sts
);
  import mau_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [MUL_CNT_BITS-1:0] cnt_r;
  logic [MUL_X_BITS-1:0]   x_r;
  logic [RES_BITS-1:0]     y_r;
  logic [RES_BITS-1:0]     acc_r;

  logic [RES_BITS:0] m_ext;
  logic [RES_BITS:0] dbl;
  logic [RES_BITS:0] dbl_red;
  logic [RES_BITS:0] sum;
  logic [RES_BITS:0] sum_red;

  // one step: acc = (2*acc + bit*y) mod m, two conditional subtracts
  always_comb begin
    m_ext   = {1'b0, modulus};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = dbl_red + (x_r[MUL_X_BITS-1] ? {1'b0, y_r} : '0);
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_BITS'(MUL_X_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.x;
      y_r   <= req.y;
      acc_r <= '0;
    end else if (busy_r) begin
      x_r   <= {x_r[MUL_X_BITS-2:0], 1'b0};
      acc_r <= sum_red[RES_BITS-1:0];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.prod = acc_r;

endmodule

`default_nettype wire

>>> hdl/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit: add, subtract, multiply, divide, power, inverse
// Works on one word at a time. A modulus below two gives a zero result
// with no reduction; otherwise both signed operands are first reduced with
// the shared bit-serial multiplier, then the operation runs: add and
// subtract in the dispatch state, multiply in one multiplier pass, power
// and inverse as a square-and-multiply loop of up to two multiplies per
// exponent bit, divide as that loop on modulus-2 plus a final multiply.
// Every multiply goes through the one shared 32-step multiplier. The input
// is stalled from acceptance until the result word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_arithmetic_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [mau_pkg::RES_BITS-1:0] cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_operation,
  input  logic signed [31:0]           in_operand_a,
  input  logic signed [31:0]           in_operand_b,
  input  logic [30:0]                  in_exponent,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mau_pkg::RES_BITS-1:0] out_result
);
  import mau_pkg::*;

  state_t state_r;
  state_t state_nxt;

  logic [RES_BITS-1:0]     modulus_r;
  op_t                     op_r;
  logic [OPERAND_BITS-1:0] a_raw_r;
  logic [OPERAND_BITS-1:0] b_raw_r;
  logic [RES_BITS-1:0]     av_r;
  logic [RES_BITS-1:0]     bv_r;
  logic [RES_BITS-1:0]     base_r;
  logic [RES_BITS-1:0]     acc_r;
  logic [RES_BITS-1:0]     e_r;
  logic [RES_BITS-1:0]     res_r;

  mul_req_t mul_req;
  mul_sts_t mul_sts;

  logic                    in_acc;
  logic [OPERAND_BITS-1:0] a_mag;
  logic [OPERAND_BITS-1:0] b_mag;
  logic                    red_neg;
  logic [RES_BITS-1:0]     red_fix;
  logic [RES_BITS:0]       add_sum;
  logic [RES_BITS:0]       add_res;
  logic [RES_BITS:0]       sub_res;
  logic                    mod_small;

  assign in_acc    = in_valid && !in_stall;
  assign mod_small = (modulus_r < RES_BITS'(2));

  // operand magnitudes and sign fix after reduction
  always_comb begin
    a_mag   = a_raw_r[OPERAND_BITS-1] ? (~a_raw_r + 1'b1) : a_raw_r;
    b_mag   = b_raw_r[OPERAND_BITS-1] ? (~b_raw_r + 1'b1) : b_raw_r;
    red_neg = (state_r == S_RED_A_W) ? a_raw_r[OPERAND_BITS-1] : b_raw_r[OPERAND_BITS-1];
    red_fix = (red_neg && (mul_sts.prod != '0)) ? (modulus_r - mul_sts.prod) : mul_sts.prod;
  end

  // add and subtract of reduced operands
  always_comb begin
    add_sum = {1'b0, av_r} + {1'b0, bv_r};
    add_res = (add_sum >= {1'b0, modulus_r}) ? (add_sum - {1'b0, modulus_r}) : add_sum;
    sub_res = (av_r >= bv_r) ? ({1'b0, av_r} - {1'b0, bv_r})
                             : ({1'b0, av_r} + {1'b0, modulus_r} - {1'b0, bv_r});
  end

  // shared multiplier
  mau_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .modulus (modulus_r),
    .sts     (mul_sts)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = mod_small ? S_OUT : S_RED_A;
      end
      S_RED_A:   state_nxt = S_RED_A_W;
      S_RED_A_W: if (mul_sts.done) state_nxt = S_RED_B;
      S_RED_B:   state_nxt = S_RED_B_W;
      S_RED_B_W: if (mul_sts.done) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (op_r)
          OP_MUL:  state_nxt = S_MUL;
          OP_DIV:  state_nxt = (bv_r == '0) ? S_OUT : S_POW_CHK;
          OP_POW:  state_nxt = S_POW_CHK;
          OP_INV:  state_nxt = (av_r == '0) ? S_OUT : S_POW_CHK;
          default: state_nxt = S_OUT;
        endcase
      end
      S_POW_CHK: begin
        priority if (e_r == '0) state_nxt = (op_r == OP_DIV) ? S_MUL : S_OUT;
        else if (e_r[0])        state_nxt = S_POW_MUL;
        else                    state_nxt = S_POW_SQR;
      end
      S_POW_MUL: state_nxt = S_POW_MUL_W;
      S_POW_MUL_W: begin
        if (mul_sts.done) state_nxt = (e_r == RES_BITS'(1)) ? S_POW_CHK : S_POW_SQR;
      end
      S_POW_SQR:   state_nxt = S_POW_SQR_W;
      S_POW_SQR_W: if (mul_sts.done) state_nxt = S_POW_CHK;
      S_MUL:       state_nxt = S_MUL_W;
      S_MUL_W:     if (mul_sts.done) state_nxt = S_OUT;
      S_OUT:       if (!out_stall) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // outputs and multiplier requests
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    out_valid     = (state_r == S_OUT);
    mul_req.start = 1'b0;
    mul_req.x     = '0;
    mul_req.y     = '0;
    unique case (state_r)
      S_RED_A: begin
        mul_req.start = 1'b1;
        mul_req.x     = MUL_X_BITS'(a_mag);
        mul_req.y     = RES_BITS'(1);
      end
      S_RED_B: begin
        mul_req.start = 1'b1;
        mul_req.x     = MUL_X_BITS'(b_mag);
        mul_req.y     = RES_BITS'(1);
      end
      S_POW_MUL: begin
        mul_req.start = 1'b1;
        mul_req.x     = MUL_X_BITS'(acc_r);
        mul_req.y     = base_r;
      end
      S_POW_SQR: begin
        mul_req.start = 1'b1;
        mul_req.x     = MUL_X_BITS'(base_r);
        mul_req.y     = base_r;
      end
      S_MUL: begin
        mul_req.start = 1'b1;
        mul_req.x     = MUL_X_BITS'(av_r);
        mul_req.y     = (op_r == OP_DIV) ? acc_r : bv_r;
      end
      default: ;
    endcase
  end

  // state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      modulus_r <= MODULUS_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) modulus_r <= cfg_wdata;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r    <= op_t'(in_operation);
          a_raw_r <= in_operand_a[OPERAND_BITS-1:0];
          b_raw_r <= in_operand_b[OPERAND_BITS-1:0];
          e_r     <= in_exponent;
          res_r   <= '0;
        end
      end
      S_RED_A_W: if (mul_sts.done) av_r <= red_fix;
      S_RED_B_W: if (mul_sts.done) bv_r <= red_fix;
      S_DISPATCH: begin
        acc_r <= RES_BITS'(1);
        unique case (op_r)
          OP_ADD: res_r <= add_res[RES_BITS-1:0];
          OP_SUB: res_r <= sub_res[RES_BITS-1:0];
          OP_DIV: begin
            base_r <= bv_r;
            e_r    <= modulus_r - RES_BITS'(2);
          end
          OP_POW: base_r <= av_r;
          OP_INV: begin
            base_r <= av_r;
            e_r    <= modulus_r - RES_BITS'(2);
          end
          default: res_r <= '0;
        endcase
      end
      S_POW_CHK: if (e_r == '0) res_r <= acc_r;
      S_POW_MUL_W: begin
        if (mul_sts.done) begin
          acc_r <= mul_sts.prod;
          if (e_r == RES_BITS'(1)) e_r <= '0;
        end
      end
      S_POW_SQR_W: begin
        if (mul_sts.done) begin
          base_r <= mul_sts.prod;
          e_r    <= {1'b0, e_r[RES_BITS-1:1]};
        end
      end
      S_MUL_W: if (mul_sts.done) res_r <= mul_sts.prod;
      default: ;
    endcase
  end

  assign out_result = res_r;

  // checks
  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_sts.busy)
    else $error("multiplier started while busy");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> (state_r == S_RED_A_W || state_r == S_RED_B_W ||
                      state_r == S_POW_MUL_W || state_r == S_POW_SQR_W ||
                      state_r == S_MUL_W))
    else $error("multiplier finished outside a wait state");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !mod_small) |-> (out_result < modulus_r))
    else $error("result not below modulus");

  a_small_mod_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mod_small) |-> (out_result == '0))
    else $error("nonzero result with modulus below two");

endmodule

`default_nettype wire

>>> dv/modular_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_test: self-checking bench for the modular unit
// Drives directed and random operation words over several modulus settings,
// predicts each residue in the bench itself and checks every result word in
// order, with random idle bursts on both channels and one long result hold.
// ----------------------------------------------------------------------------

module modular_arithmetic_unit_test;

  import mau_pkg::*;

  // codes with no operation behind them
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int LONG_HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int END_CYCLES       = 50;
  localparam int QUIET_LIMIT      = 30000;
  localparam int WORDS_PER_PHASE  = 26;
  localparam int RANDOM_PHASES    = 10;

  typedef struct {
    int unsigned         tag;
    logic [RES_BITS-1:0] value;
  } residue_entry_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [RES_BITS-1:0] cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [2:0]          in_operation = '0;
  logic signed [31:0]  in_operand_a = '0;
  logic signed [31:0]  in_operand_b = '0;
  logic [30:0]         in_exponent  = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [RES_BITS-1:0] out_result;

  residue_entry_t      pending_residues[$];
  logic [RES_BITS-1:0] modulus_now     = MODULUS_RESET;
  int unsigned         words_sent      = 0;
  int unsigned         mismatch_count  = 0;
  int unsigned         quiet_cycles    = 0;
  bit                  gaps_on         = 1'b1;
  bit                  stall_on        = 1'b1;
  bit                  hold_results    = 1'b0;

  modular_arithmetic_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // signed operand folded into 0 .. m-1
  function automatic longint unsigned fold_operand(input logic signed [31:0] x,
                                                   input longint unsigned m);
    longint r;
    r = longint'(x) % longint'(m);
    if (r < 0) r += longint'(m);
    return longint'(r);
  endfunction

  // square-and-multiply, products at full width
  function automatic longint unsigned pow_residue(input longint unsigned base,
                                                  input longint unsigned e,
                                                  input longint unsigned m);
    longint unsigned acc, sq, k;
    acc = 1 % m;
    sq  = base;
    k   = e;
    while (k != 0) begin
      if (k[0]) acc = (acc * sq) % m;
      k  = k >> 1;
      sq = (sq * sq) % m;
    end
    return acc;
  endfunction

  function automatic logic [RES_BITS-1:0] expected_residue(input logic [2:0] op,
                                                           input logic signed [31:0] a_raw,
                                                           input logic signed [31:0] b_raw,
                                                           input logic [30:0] e,
                                                           input logic [RES_BITS-1:0] m);
    longint unsigned mm, a, b, r;
    // modulus below two gives zero for everything
    if (m < 2) return '0;
    mm = m;
    a  = fold_operand(a_raw, mm);
    b  = fold_operand(b_raw, mm);
    case (op)
      OP_ADD:  r = (a + b) % mm;
      OP_SUB:  r = (a + mm - b) % mm;
      OP_MUL:  r = (a * b) % mm;
      OP_DIV:  r = (b == 0) ? 0 : (a * pow_residue(b, mm - 2, mm)) % mm;
      OP_POW:  r = pow_residue(a, e, mm);
      OP_INV:  r = (a == 0) ? 0 : pow_residue(a, mm - 2, mm);
      default: r = 0;
    endcase
    return r[RES_BITS-1:0];
  endfunction

  // random operand: full range, small signed, or a multiple of the modulus
  function automatic logic signed [31:0] random_operand(input logic [RES_BITS-1:0] m);
    logic signed [31:0] v;
    case ($urandom_range(0, 4))
      0:       v = $signed(32'($urandom_range(0, 20))) - 32'sd10;
      1:       v = $signed({1'b0, m});
      2:       v = -$signed({1'b0, m});
      default: v = $signed($urandom());
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned tag,
                                 input logic [RES_BITS-1:0] got,
                                 input logic [RES_BITS-1:0] want);
    $display("mismatch (%s) word %0d: got %0d expected %0d", what, tag, got, want);
    mismatch_count++;
  endtask

  // one word on the input channel, expectation queued on acceptance
  task automatic send_word(input logic [2:0] op, input logic signed [31:0] a,
                           input logic signed [31:0] b, input logic [30:0] e);
    residue_entry_t entry;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_exponent  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entry.tag   = words_sent;
    entry.value = expected_residue(op, a, b, e, modulus_now);
    pending_residues.insert(pending_residues.size(), entry);
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_modulus(input logic [RES_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    modulus_now  = value;
  endtask

  // extremes and special cases under the reset modulus
  task automatic test_reset_modulus();
    send_word(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 31'd0);
    send_word(OP_SUB, -32'sd1, 32'sh7fff_ffff, 31'd0);
    send_word(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 31'd0);
    // zero divisor
    send_word(OP_DIV, 32'sd123456789, 32'sd1000000007, 31'd0);
    send_word(OP_DIV, -32'sd5, 32'sd987654321, 31'd0);
    // zero exponent, then the largest one
    send_word(OP_POW, -32'sd2, 32'sd0, 31'd0);
    send_word(OP_POW, 32'sd3, 32'sd0, 31'h7fff_ffff);
    // inverse of something that folds to zero
    send_word(OP_INV, -32'sd1000000007, 32'sd0, 31'd0);
    send_word(OP_INV, 32'sd2, 32'sd0, 31'd0);
    send_word(OP_SPARE_6, 32'sd17, 32'sd4, 31'd9);
    send_word(OP_SPARE_7, -32'sd1, -32'sd1, 31'h7fff_ffff);
    wait_for_results();
  endtask

  // largest, smallest, degenerate and composite moduli
  task automatic test_modulus_extremes();
    set_modulus(31'h7fff_ffff);
    send_word(OP_POW, -32'sd1, 32'sd5, 31'h7fff_ffff);
    send_word(OP_DIV, 32'sh7fff_ffff, 32'sh8000_0000, 31'd0);
    wait_for_results();
    set_modulus(31'd2);
    send_word(OP_INV, 32'sd1, 32'sd0, 31'd0);
    send_word(OP_SUB, 32'sd0, 32'sd1, 31'd0);
    wait_for_results();
    set_modulus(31'd1);
    send_word(OP_MUL, 32'sd7, 32'sd9, 31'd0);
    send_word(OP_POW, 32'sd7, 32'sd0, 31'd0);
    wait_for_results();
    set_modulus(31'd0);
    send_word(OP_ADD, 32'sd5, 32'sd6, 31'd0);
    send_word(OP_INV, 32'sd3, 32'sd0, 31'd0);
    wait_for_results();
    set_modulus(31'd1000000);
    send_word(OP_INV, 32'sd3, 32'sd0, 31'd0);
    send_word(OP_DIV, 32'sd7, -32'sd9, 31'd0);
    wait_for_results();
  endtask

  // results held off for a long stretch while further words wait at the input
  task automatic test_result_backpressure();
    set_modulus(31'd65537);
    hold_results = 1'b1;
    repeat (6) send_word(OP_POW, random_operand(modulus_now), random_operand(modulus_now),
                         31'($urandom()));
    wait_for_results();
  endtask

  task automatic test_random_mix();
    logic [RES_BITS-1:0] m;
    logic [2:0]          op;
    logic [30:0]         e;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       m = 31'd3;
        1:       m = 31'd7;
        2:       m = 31'd251;
        3:       m = 31'd65537;
        4:       m = 31'd998244353;
        5:       m = 31'd1000000007;
        6:       m = 31'h7fff_ffff;
        7:       m = 31'd2147483629;
        default: m = 31'($urandom_range(2, 32'h7fff_ffff));
      endcase
      // last phase runs with no idling
      gaps_on  = (phase != RANDOM_PHASES - 1);
      stall_on = gaps_on;
      set_modulus(m);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 15) == 0) op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        else op = 3'($urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0) e = 31'($urandom_range(0, 16));
        else e = 31'($urandom());
        send_word(op, random_operand(m), random_operand(m), e);
      end
      wait_for_results();
    end
  endtask

  // result channel stall: random bursts, one long hold on request
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result word with the oldest pending residue
  always @(posedge clk) begin : check_results
    residue_entry_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_residues.size() == 0) begin
        report_mismatch("nothing pending", words_sent, out_result, '0);
      end else begin
        want = pending_residues.pop_front();
        if (out_result !== want.value) report_mismatch("result", want.tag, out_result,
                                                       want.value);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_modulus();
    test_modulus_extremes();
    test_result_backpressure();
    test_random_mix();
    wait_for_results();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
